/* design/char_lcd_expander_sequencer_defines.svh */
// assertion macros for the character display sequencer
`ifndef CHAR_LCD_EXPANDER_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_EXPANDER_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

`define CLSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication violated");

`define CLSE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define CLSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define CLSE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* design/clse_pkg.sv */
// shared types, constants and tables for the character display sequencer
`default_nettype none

package clse_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_CURSOR = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic REG_BACKLIGHT = 1'b0;
    localparam logic REG_ADDRESS   = 1'b1;

    localparam logic [7:0] DDRAM_SET = 8'h80;

    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd23;
    localparam logic [STEP_W-1:0] INIT_NIB_STEPS = 5'd8;

    localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
    localparam logic [3:0] INIT_NIB_MODE = 4'h2;

    localparam logic [1:0] ROW_MAX = 2'd3;

    typedef struct packed {
        logic       is_init;
        logic [7:0] data;
        logic       rs;
    } t_job;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0: base = 8'h00;
            2'd1: base = 8'h40;
            2'd2: base = 8'h14;
            2'd3: base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h0C;
            2'd2: b = 8'h01;
            2'd3: b = 8'h06;
            default: b = 8'h28;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* design/char_lcd_expander_sequencer.sv */
// top level of the character display sequencer over an i2c port expander
//
// requests enter through a queue-style port: a word is taken at a clock edge
// with push high and full low. cmd 0 writes value as a command or data byte,
// cmd 1 sets the cursor from row and col, cmd 2 runs the power-up sequence,
// cmd 3 is taken and dropped.
// results leave through a queue-style port: while empty is low the oldest
// expander transaction is on o_address_byte and o_port_byte, and it is taken
// at an edge with pop high. o_last marks the final transaction of a request.
// the transactions of a request are registered into the output word once the sequencer reaches it in the job queue.
// a byte write or cursor set gives 4 transactions and an initialisation 24,
// at one transaction per cycle while pop stays high, set by the single step counter of the
// sequencer; a two-entry job queue lets new requests enter meanwhile.
// when pop stays low the output word holds and the sequencer waits; full
// rises once two requests are queued.
// reset empties both queues and sets backlight on and address 0x27.
// configuration writes (i_cfg_we) are made only while the block is idle; the block itself does not enforce this.
`default_nettype none

module char_lcd_expander_sequencer
    import clse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_value,
    input  wire logic       i_is_data,
    input  wire logic [7:0] i_row,
    input  wire logic [7:0] i_col,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_address_byte,
    output logic [7:0]      o_port_byte,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [6:0] i_cfg_data
);

    logic       r_backlight_on;
    logic [6:0] r_expander_address;

    logic       s_job_valid;
    t_job       s_job;
    logic       s_job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight_on     <= 1'b1;
            r_expander_address <= 7'd39;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ADDRESS) begin
                r_expander_address <= i_cfg_data;
            end else begin
                r_backlight_on <= i_cfg_data[0];
            end
        end
    end

    clse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_is_data   (i_is_data),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_job_valid (s_job_valid),
        .o_job       (s_job),
        .i_job_pop   (s_job_pop)
    );

    clse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (s_job_valid),
        .i_job          (s_job),
        .o_job_pop      (s_job_pop),
        .i_backlight_on (r_backlight_on),
        .empty          (empty),
        .pop            (pop),
        .o_port_byte    (o_port_byte),
        .o_last         (o_last)
    );

    assign o_address_byte = {r_expander_address, 1'b0};

endmodule

`default_nettype wire

/* design/clse_front.sv */
// request decode and two-entry job queue
`default_nettype none
`include "char_lcd_expander_sequencer_defines.svh"

module clse_front
    import clse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_value,
    input  wire logic       i_is_data,
    input  wire logic [7:0] i_row,
    input  wire logic [7:0] i_col,
    output logic            o_job_valid,
    output t_job            o_job,
    input  wire logic       i_job_pop
);

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    t_job       s_job;
    logic       s_wr;
    logic [1:0] s_row;
    logic [7:0] s_addr;

    always_comb begin
        s_row  = (i_row > {6'd0, ROW_MAX}) ? ROW_MAX : i_row[1:0];
        s_addr = row_base(s_row) + i_col;
        s_job  = '0;
        unique case (i_cmd)
            CMD_WRITE: begin
                s_job.data = i_value;
                s_job.rs   = i_is_data;
            end
            CMD_CURSOR: begin
                s_job.data = DDRAM_SET | s_addr;
            end
            CMD_INIT: begin
                s_job.is_init = 1'b1;
            end
            default: begin
                s_job = '0;
            end
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign s_wr        = push && !full && (i_cmd != CMD_UNUSED);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (s_wr && !i_job_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!s_wr && i_job_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (s_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wp] <= s_job;
        end
    end

    `CLSE_ASSERT_NEVER(a_front_cnt_range, i_clk, i_rst_n, r_cnt > 2'd2)
    `CLSE_ASSERT_IMPLY(a_front_pop_nonempty, i_clk, i_rst_n, i_job_pop, r_cnt != 2'd0)

endmodule

`default_nettype wire

/* design/clse_back.sv */
// transaction sequencer and output word register
`default_nettype none
`include "char_lcd_expander_sequencer_defines.svh"

module clse_back
    import clse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    input  wire logic i_backlight_on,
    output logic      empty,
    input  wire logic pop,
    output logic [7:0] o_port_byte,
    output logic      o_last
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [7:0]        r_port;
    logic              r_last;

    logic [STEP_W-1:0] s_ofs;
    logic [7:0]        s_ib;
    logic [3:0]        s_nib;
    logic              s_is_last;
    logic              s_adv;
    logic              s_take;

    always_comb begin
        s_ofs = r_step - INIT_NIB_STEPS;
        s_ib  = init_byte(s_ofs[3:2]);
        priority if (!i_job.is_init) begin
            s_nib = r_step[1] ? i_job.data[3:0] : i_job.data[7:4];
        end else if (r_step < INIT_NIB_STEPS) begin
            s_nib = (r_step[2:1] == 2'd3) ? INIT_NIB_MODE : INIT_NIB_WAKE;
        end else begin
            s_nib = s_ofs[1] ? s_ib[3:0] : s_ib[7:4];
        end
        s_is_last = i_job.is_init ? (r_step == INIT_LAST_STEP)
                                  : (r_step == BYTE_LAST_STEP);
    end

    assign s_take    = pop && r_out_valid;
    assign s_adv     = i_job_valid && (!r_out_valid || s_take);
    assign o_job_pop = s_adv && s_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_adv) begin
                r_step      <= s_is_last ? '0 : r_step + 1'b1;
                r_out_valid <= 1'b1;
            end else if (s_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_port <= {s_nib, i_backlight_on, ~r_step[0], 1'b0, i_job.rs};
            r_last <= s_is_last;
        end
    end

    assign empty       = !r_out_valid;
    assign o_port_byte = r_port;
    assign o_last      = r_last;

    `CLSE_ASSERT_NEVER(a_back_step_range, i_clk, i_rst_n, r_step > INIT_LAST_STEP)
    `CLSE_ASSERT_IMPLY(a_back_byte_steps, i_clk, i_rst_n,
                       i_job_valid && !i_job.is_init, r_step <= BYTE_LAST_STEP)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the character display sequencer over an i2c port expander
module testbench;
    import clse_pkg::*;

    localparam logic [7:0] PORT_RS       = 8'h01;
    localparam logic [7:0] PORT_EN       = 8'h04;
    localparam logic [7:0] PORT_BL       = 8'h08;
    localparam int         SETTLE_CYCLES = 12;

    localparam logic [7:0] DDRAM_ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
    localparam logic [7:0] WAKE_NIBBLES [4] = '{8'h30, 8'h30, 8'h30, 8'h20};
    localparam logic [7:0] SETUP_BYTES [4]  = '{8'h28, 8'h0C, 8'h01, 8'h06};

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] port_byte;
        logic       last;
    } t_lcd_word;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       push       = 1'b0;
    logic [1:0] i_cmd      = CMD_WRITE;
    logic [7:0] i_value    = 8'h00;
    logic       i_is_data  = 1'b0;
    logic [7:0] i_row      = 8'h00;
    logic [7:0] i_col      = 8'h00;
    logic       pop        = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = REG_BACKLIGHT;
    logic [6:0] i_cfg_data = 7'h00;
    logic       full;
    logic       empty;
    logic [7:0] o_address_byte;
    logic [7:0] o_port_byte;
    logic       o_last;

    t_lcd_word  pending_words[$];
    logic       model_backlight = 1'b1;
    logic [6:0] model_address   = 7'd39;
    int         send_idle_pct   = 0;
    int         recv_idle_pct   = 0;
    int         error_count     = 0;

    char_lcd_expander_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_is_data      (i_is_data),
        .i_row          (i_row),
        .i_col          (i_col),
        .empty          (empty),
        .pop            (pop),
        .o_address_byte (o_address_byte),
        .o_port_byte    (o_port_byte),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // one nibble gives an enable-high word then an enable-low word
    function automatic void add_nibble(input logic [7:0] nib, input logic rs);
        logic [7:0] port;
        port = (nib & 8'hF0) | (rs ? PORT_RS : 8'h00) | (model_backlight ? PORT_BL : 8'h00);
        pending_words.push_back('{{model_address, 1'b0}, port | PORT_EN, 1'b0});
        pending_words.push_back('{{model_address, 1'b0}, port & ~PORT_EN, 1'b0});
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic rs);
        add_nibble(b & 8'hF0, rs);
        add_nibble({b[3:0], 4'h0}, rs);
    endfunction

    function automatic void predict_transactions(input logic [1:0] cmd, input logic [7:0] value,
                                                 input logic is_data, input logic [7:0] row,
                                                 input logic [7:0] col);
        logic [1:0] row_clamped;
        logic [7:0] ddram_addr;
        row_clamped = (row > 8'd3) ? 2'd3 : row[1:0];
        ddram_addr  = DDRAM_ROW_OFFSET[row_clamped] + col;
        case (cmd)
            CMD_WRITE: begin
                add_byte(value, is_data);
            end
            CMD_CURSOR: begin
                add_byte(DDRAM_SET | ddram_addr, 1'b0);
            end
            CMD_INIT: begin
                for (int i = 0; i < 4; i++) add_nibble(WAKE_NIBBLES[i], 1'b0);
                for (int i = 0; i < 4; i++) add_byte(SETUP_BYTES[i], 1'b0);
            end
            default: return;
        endcase
        pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] value,
                                input logic is_data, input logic [7:0] row,
                                input logic [7:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_cmd     <= cmd;
        i_value   <= value;
        i_is_data <= is_data;
        i_row     <= row;
        i_col     <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_transactions(cmd, value, is_data, row, col);
    endtask

    task automatic drain_outstanding();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_registers(input logic backlight, input logic [6:0] address);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BACKLIGHT;
        i_cfg_data <= {6'($urandom_range(63)), backlight};
        @(posedge i_clk);
        model_backlight = backlight;
        i_cfg_idx  <= REG_ADDRESS;
        i_cfg_data <= address;
        @(posedge i_clk);
        model_address = address;
        i_cfg_we <= 1'b0;
    endtask

    // result side: compare each popped word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_lcd_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected word: address_byte %02h port_byte %02h last %0b",
                           o_address_byte, o_port_byte, o_last);
                    error_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_address_byte !== want.address_byte) begin
                        $error("address_byte expected %02h got %02h",
                               want.address_byte, o_address_byte);
                        error_count++;
                    end
                    if (o_port_byte !== want.port_byte) begin
                        $error("port_byte expected %02h got %02h", want.port_byte, o_port_byte);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0b got %0b", want.last, o_last);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // reset values, every request kind, field extremes and the cursor wrap
    task automatic test_directed();
        send_request(CMD_WRITE, 8'h00, 1'b0, 8'h00, 8'h00);
        send_request(CMD_WRITE, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_request(CMD_WRITE, 8'hA5, 1'b1, 8'h00, 8'h00);
        send_request(CMD_WRITE, 8'h5A, 1'b0, 8'h00, 8'h00);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd0, 8'd0);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd1, 8'd5);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd2, 8'd19);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd3, 8'd0);
        send_request(CMD_CURSOR, 8'hFF, 1'b1, 8'd4, 8'd7);
        send_request(CMD_CURSOR, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd1, 8'hC0);
        send_request(CMD_INIT, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_request(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_request(CMD_WRITE, 8'h3C, 1'b1, 8'h00, 8'h00);
        send_request(CMD_UNUSED, 8'h00, 1'b0, 8'h00, 8'h00);
        send_request(CMD_INIT, 8'h00, 1'b0, 8'h00, 8'h00);
        drain_outstanding();
    endtask

    // backlight and address at their extremes; changes show only in later words
    task automatic test_register_extremes();
        set_registers(1'b0, 7'd0);
        send_request(CMD_WRITE, 8'hFF, 1'b1, 8'h00, 8'h00);
        send_request(CMD_CURSOR, 8'h00, 1'b0, 8'd3, 8'hAC);
        send_request(CMD_UNUSED, 8'h12, 1'b1, 8'h34, 8'h56);
        drain_outstanding();
        set_registers(1'b1, 7'd127);
        send_request(CMD_WRITE, 8'h00, 1'b0, 8'h00, 8'h00);
        send_request(CMD_INIT, 8'h00, 1'b0, 8'h00, 8'h00);
        drain_outstanding();
        set_registers(1'b0, 7'h55);
        send_request(CMD_WRITE, 8'h96, 1'b1, 8'h00, 8'h00);
        drain_outstanding();
        set_registers(1'b1, 7'h2A);
        send_request(CMD_WRITE, 8'h69, 1'b0, 8'h00, 8'h00);
        drain_outstanding();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int         accepted;
        int         pick;
        logic [1:0] cmd;
        logic [7:0] row;
        accepted = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_registers(1'($urandom_range(1)), 7'($urandom_range(127)));
        while (accepted < count) begin
            pick = $urandom_range(99);
            if (pick < 60) cmd = CMD_WRITE;
            else if (pick < 85) cmd = CMD_CURSOR;
            else if (pick < 92) cmd = CMD_INIT;
            else cmd = CMD_UNUSED;
            row = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
            send_request(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)), row,
                         8'($urandom_range(255)));
            if (cmd != CMD_UNUSED) accepted++;
        end
        drain_outstanding();
    endtask

    initial begin
        send_idle_pct = 20;
        recv_idle_pct = 59;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_random_traffic(105, 20, 59);
        test_random_traffic(105, 59, 20);
        test_random_traffic(105, 0, 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("char_lcd_expander_sequencer test passed");
        end else begin
            $display("char_lcd_expander_sequencer test failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("char_lcd_expander_sequencer test failed");
        $finish;
    end

endmodule
